### hdl/lpot_pkg.sv
// Package for the LRU page order tracker: request and result structs,
// operation codes and default sizes. Depends on nothing.
`timescale 1ns / 1ps

package lpot_pkg;

  localparam int DEPTH_DEF    = 16;
  localparam int KEY_BITS_DEF = 16;

  localparam int PAGE_KEY_W = 16;
  localparam int OCC_W      = 5;
  localparam int CAP_W      = 5;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  localparam logic OP_REF   = 1'b0;
  localparam logic OP_EVICT = 1'b1;

  typedef struct packed {
    logic                  op;
    logic [PAGE_KEY_W-1:0] page_key;
  } lpot_req_t;

  typedef struct packed {
    logic                  hit;
    logic                  inserted;
    logic                  full_refused;
    logic                  evicted_valid;
    logic [PAGE_KEY_W-1:0] evicted_key;
    logic [OCC_W-1:0]      occupancy;
  } lpot_res_t;

endpackage

### hdl/lru_page_order_tracker_top.sv
// Top level of the LRU page order tracker: request sequencer and the key
// store. Depends on lpot_pkg and lpot_key_ram.
`timescale 1ns / 1ps

// Channel      Signals               Direction  Handshake
// request      start, req            in         taken when start && !busy
// result       done, res             out        one-cycle strobe, no back-pressure
// config       cfg_we, cfg_wdata     in         written on any edge with cfg_we high
//
// The keys live in a circular buffer in one synchronous RAM, oldest at the
// head pointer. An evict drops the key at the head; a reference on an
// empty list stores its key at once. Any other reference searches from
// the oldest key through the RAM read port, one entry per cycle; a miss
// appends the key if there is room, and a hit on any key but the newest
// is followed by a shift that closes the gap it leaves. A new request may
// be taken in the cycle its predecessor's result is shown. Reset empties
// the list at once (no clearing pass) and sets the capacity to 16. The
// receiver cannot stall, so each result is shown for one cycle only.

module lru_page_order_tracker_top #(
  parameter int DEPTH    = lpot_pkg::DEPTH_DEF,
  parameter int KEY_BITS = lpot_pkg::KEY_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  lpot_pkg::lpot_req_t      req,
  output logic                     done,
  output lpot_pkg::lpot_res_t      res,
  input  logic                     cfg_we,
  input  logic [lpot_pkg::CAP_W-1:0] cfg_wdata
);

  import lpot_pkg::*;

  // Address width of the RAM and width of the key count, which must hold
  // DEPTH itself.
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = AW + CW + 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_TAIL,
    S_EVICT
  } state_t;

  state_t              state;
  logic [CAP_W-1:0]    capacity;
  logic [AW-1:0]       head;
  logic [CW-1:0]       count;
  logic [AW-1:0]       idx;
  logic [KEY_BITS-1:0] key;

  logic                wr_en;
  logic [AW-1:0]       wr_addr;
  logic [KEY_BITS-1:0] wr_data;
  logic [AW-1:0]       rd_addr;
  logic [KEY_BITS-1:0] rd_data;

  logic [KEY_BITS-1:0] key_in;
  logic [CW-1:0]       idx_ext;
  logic [CW-1:0]       cap_eff;
  logic                at_last;
  logic                match;
  logic                room;

  // Maps a distance from the oldest key to a RAM address. The sum stays
  // below twice DEPTH, so one conditional subtract wraps it.
  function automatic logic [AW-1:0] slot(input logic [AW-1:0] h, input logic [CW-1:0] off);
    logic [SW-1:0] s;
    s = SW'(h) + SW'(off);
    if (s >= SW'(DEPTH)) begin
      s = s - SW'(DEPTH);
    end
    return AW'(s);
  endfunction

  // Builds a complete result so that each result is written in one piece.
  function automatic lpot_res_t make_res(input logic h, input logic ins, input logic refd,
                                         input logic evv, input logic [PAGE_KEY_W-1:0] evk,
                                         input logic [OCC_W-1:0] occ);
    lpot_res_t r;
    r.hit           = h;
    r.inserted      = ins;
    r.full_refused  = refd;
    r.evicted_valid = evv;
    r.evicted_key   = evk;
    r.occupancy     = occ;
    return r;
  endfunction

  assign key_in  = KEY_BITS'(req.page_key);
  assign idx_ext = CW'(idx);
  assign at_last = (idx_ext == count - CW'(1));
  assign match   = (rd_data == key);

  // A zero capacity acts as one frame; anything above DEPTH saturates.
  always_comb begin
    if (capacity == '0) begin
      cap_eff = CW'(1);
    end else if (int'(capacity) > DEPTH) begin
      cap_eff = CW'(DEPTH);
    end else begin
      cap_eff = CW'(capacity);
    end
  end

  assign room = (count < cap_eff);
  assign busy = (state != S_IDLE);

  // RAM port control. During the search each cycle reads the entry after the
  // one being compared, so a hit can start shifting without a bubble. The
  // shift writes entry idx while it reads idx + 2, so the two never collide.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = head;
    wr_data = key;
    rd_addr = head;
    unique case (state)
      S_IDLE: begin
        if (start && (req.op == OP_REF) && (count == '0)) begin
          wr_en   = 1'b1;
          wr_data = key_in;
        end
      end
      S_SCAN: begin
        rd_addr = slot(head, idx_ext + CW'(1));
        if (!match && at_last && room) begin
          wr_en   = 1'b1;
          wr_addr = slot(head, count);
        end
      end
      S_SHIFT: begin
        rd_addr = slot(head, idx_ext + CW'(2));
        wr_en   = 1'b1;
        wr_addr = slot(head, idx_ext);
        wr_data = rd_data;
      end
      S_TAIL: begin
        wr_en   = 1'b1;
        wr_addr = slot(head, idx_ext);
      end
      S_EVICT: begin
        rd_addr = head;
      end
      default: begin
        rd_addr = head;
      end
    endcase
  end

  // Sequencer, list bookkeeping and the registered result.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      done     <= 1'b0;
      head     <= '0;
      count    <= '0;
      capacity <= CAP_RESET;
    end else begin
      done <= 1'b0;
      if (cfg_we) begin
        capacity <= cfg_wdata;
      end
      unique case (state)
        S_IDLE: begin
          if (start) begin
            key <= key_in;
            idx <= '0;
            if (req.op == OP_EVICT) begin
              if (count == '0) begin
                done <= 1'b1;
                res  <= make_res(1'b0, 1'b0, 1'b0, 1'b0, '0, OCC_W'(count));
              end else begin
                state <= S_EVICT;
              end
            end else if (count == '0) begin
              // An empty list always has room for one key.
              done  <= 1'b1;
              res   <= make_res(1'b0, 1'b1, 1'b0, 1'b0, '0, OCC_W'(CW'(1)));
              count <= CW'(1);
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (match) begin
            if (at_last) begin
              done  <= 1'b1;
              res   <= make_res(1'b1, 1'b0, 1'b0, 1'b0, '0, OCC_W'(count));
              state <= S_IDLE;
            end else begin
              state <= S_SHIFT;
            end
          end else if (at_last) begin
            done  <= 1'b1;
            state <= S_IDLE;
            if (room) begin
              res   <= make_res(1'b0, 1'b1, 1'b0, 1'b0, '0, OCC_W'(count + CW'(1)));
              count <= count + CW'(1);
            end else begin
              res <= make_res(1'b0, 1'b0, 1'b1, 1'b0, '0, OCC_W'(count));
            end
          end else begin
            idx <= idx + AW'(1);
          end
        end
        S_SHIFT: begin
          if (idx_ext + CW'(1) == count - CW'(1)) begin
            state <= S_TAIL;
          end
          idx <= idx + AW'(1);
        end
        S_TAIL: begin
          done  <= 1'b1;
          res   <= make_res(1'b1, 1'b0, 1'b0, 1'b0, '0, OCC_W'(count));
          state <= S_IDLE;
        end
        S_EVICT: begin
          done  <= 1'b1;
          res   <= make_res(1'b0, 1'b0, 1'b0, 1'b1, PAGE_KEY_W'(rd_data),
                            OCC_W'(count - CW'(1)));
          count <= count - CW'(1);
          head  <= slot(head, CW'(1));
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  lpot_key_ram #(
    .DEPTH    (DEPTH),
    .KEY_BITS (KEY_BITS),
    .AW       (AW)
  ) u_key_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

endmodule

### hdl/lpot_key_ram.sv
// Key store of the LRU page order tracker: one write port and one read
// port with registered read data. No package dependencies.
`timescale 1ns / 1ps

module lpot_key_ram #(
  parameter int DEPTH    = 16,
  parameter int KEY_BITS = 16,
  parameter int AW       = $clog2(DEPTH)
) (
  input  logic                clk,
  input  logic                wr_en,
  input  logic [AW-1:0]       wr_addr,
  input  logic [KEY_BITS-1:0] wr_data,
  input  logic [AW-1:0]       rd_addr,
  output logic [KEY_BITS-1:0] rd_data
);

  logic [KEY_BITS-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

### hdl/lpot_checker.sv
// Port-level checks for the LRU page order tracker and the bind that
// attaches them to the top level. Depends on lpot_pkg.
`timescale 1ns / 1ps

module lpot_checker (
  input logic                clk,
  input logic                rst,
  input logic                start,
  input logic                busy,
  input logic                done,
  input lpot_pkg::lpot_res_t res
);

  import lpot_pkg::*;

  // A taken request either answers at once or keeps the block busy.
  a_start_progress: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (done || busy))
    else $error("request taken but neither busy nor done followed");

  // The block only leaves its busy phase by delivering a result.
  a_busy_ends_done: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> done)
    else $error("busy dropped without a result");

  // At most one outcome flag per result.
  a_one_outcome: assert property (@(posedge clk) disable iff (rst)
    done |-> ($countones({res.hit, res.inserted, res.full_refused,
                          res.evicted_valid}) <= 1))
    else $error("result carries more than one outcome");

  // An evicted key is reported only with its valid flag.
  a_key_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !res.evicted_valid) |-> (res.evicted_key == '0))
    else $error("evicted key nonzero without an eviction");

endmodule

bind lru_page_order_tracker_top lpot_checker u_lpot_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done),
  .res   (res)
);
